// ===== hw/rtl/idv_pkg.sv =====
// ----------------------------------------------------------------------------
// idv_pkg: shared types, constants and a helper for the identity number check
// Character codes, position limits and the mod-10 helper used by the
// accumulator and the check stage.
// ----------------------------------------------------------------------------
`default_nettype none

package idv_pkg;

	// Character codes and string geometry
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [3:0] ID_LEN    = 4'd11;
	localparam logic [3:0] CNT_SAT   = 4'd12;
	localparam logic [3:0] CHK_POS   = 4'd9;
	localparam logic [3:0] FINAL_POS = 4'd10;

	// Reciprocal of ten: floor(x / 10) == (x * 205) >> 11 for x < 1029
	localparam logic [7:0] RECIP10   = 8'd205;
	localparam int         RECIP_SH  = 11;

	// Snapshot of the accumulated string, handed to the check stage
	typedef struct packed {
		logic       base_ok;  // length, digits-only and leading-digit checks
		logic       wsum_neg; // weighted sum is negative
		logic [8:0] wsum_mag; // magnitude of 7*odd - even
		logic [3:0] tenth;    // digit at position 9
		logic [6:0] sum10;    // sum of digits 0..9
		logic [3:0] fin;      // digit at position 10
	} snap_t;

	// Remainder of a 9-bit value by ten (reciprocal multiply and correction)
	function automatic logic [3:0] mod10(input logic [8:0] x);
		logic [16:0] prod;
		logic [5:0]  quo;
		logic [8:0]  quo10;
		logic [8:0]  rem;
		prod  = x * RECIP10;
		quo   = prod[16:RECIP_SH];
		quo10 = {quo, 3'b000} + {2'b00, quo, 1'b0};
		rem   = x - quo10;
		return rem[3:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/idv_acc.sv =====
// ----------------------------------------------------------------------------
// idv_acc: per-string accumulator
// Holds the running count, flags and digit sums of the string in flight and
// presents the updated snapshot for the transaction being retired.
// ----------------------------------------------------------------------------
`default_nettype none

module idv_acc (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    ch_s1,
	input  wire logic          last_s1,
	input  wire logic          upd,
	output idv_pkg::snap_t     snap
);

	logic [3:0] count_q;
	logic       nondig_q;
	logic       lz_q;
	logic [5:0] odd_q;
	logic [5:0] even_q;
	logic [6:0] sum10_q;
	logic [3:0] tenth_q;

	logic       is_digit;
	logic [3:0] dig;
	logic [7:0] ch_off;
	logic [3:0] count_n;
	logic       nondig_n;
	logic       lz_n;
	logic [5:0] odd_n;
	logic [5:0] even_n;
	logic [6:0] sum10_n;
	logic [3:0] tenth_n;
	logic [3:0] fin_n;
	logic [9:0] odd_x7;
	logic [9:0] wsum;

	// Digit decode
	assign is_digit = (ch_s1 >= idv_pkg::CHAR_ZERO) && (ch_s1 <= idv_pkg::CHAR_NINE);
	assign ch_off   = ch_s1 - idv_pkg::CHAR_ZERO;
	assign dig      = is_digit ? ch_off[3:0] : 4'd0;

	// Next state for this character
	always_comb begin
		count_n  = (count_q < idv_pkg::CNT_SAT) ? count_q + 4'd1 : count_q;
		nondig_n = nondig_q | ~is_digit;
		lz_n     = lz_q | ((count_q == 4'd0) && (ch_s1 == idv_pkg::CHAR_ZERO));
		odd_n    = odd_q;
		even_n   = even_q;
		sum10_n  = sum10_q;
		tenth_n  = tenth_q;
		fin_n    = (count_q == idv_pkg::FINAL_POS) ? dig : 4'd0;
		if (is_digit && (count_q < idv_pkg::FINAL_POS)) begin
			sum10_n = sum10_q + {3'd0, dig};
			if (count_q < idv_pkg::CHK_POS) begin
				if (!count_q[0]) begin
					odd_n = odd_q + {2'd0, dig};
				end else begin
					even_n = even_q + {2'd0, dig};
				end
			end else begin
				tenth_n = dig;
			end
		end
	end

	// Weighted sum 7*odd - even, range -36..315
	assign odd_x7 = {1'b0, odd_n, 3'b000} - {4'd0, odd_n};
	assign wsum   = odd_x7 - {4'd0, even_n};

	always_comb begin
		snap.base_ok  = (count_n == idv_pkg::ID_LEN) && !nondig_n && !lz_n;
		snap.wsum_neg = wsum[9];
		snap.wsum_mag = wsum[9] ? 9'(-wsum) : wsum[8:0];
		snap.tenth    = tenth_n;
		snap.sum10    = sum10_n;
		snap.fin      = fin_n;
	end

	// State registers: cleared after the final character of each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			nondig_q <= 1'b0;
			lz_q     <= 1'b0;
			odd_q    <= '0;
			even_q   <= '0;
			sum10_q  <= '0;
			tenth_q  <= '0;
		end else if (upd) begin
			if (last_s1) begin
				count_q  <= '0;
				nondig_q <= 1'b0;
				lz_q     <= 1'b0;
				odd_q    <= '0;
				even_q   <= '0;
				sum10_q  <= '0;
				tenth_q  <= '0;
			end else begin
				count_q  <= count_n;
				nondig_q <= nondig_n;
				lz_q     <= lz_n;
				odd_q    <= odd_n;
				even_q   <= even_n;
				sum10_q  <= sum10_n;
				tenth_q  <= tenth_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/identity_number_check_digit_validator.sv =====
// ----------------------------------------------------------------------------
// identity_number_check_digit_validator: identity number check-digit validator
// Streams an identity number one character per transaction and returns one
// verdict on the transaction flagged last.
// ----------------------------------------------------------------------------
// One character is accepted every clock cycle. A transaction passes an input
// register, the accumulator stage (running sums and flags, plus the weighted
// sum 7*odd - even) and the check stage (two mod-10 reductions and compares)
// that loads the result register. Only the final character of a string
// produces a result transaction; the accumulated state clears behind it, so
// the next string may start in the following cycle. Input stalls only when
// all stages are occupied behind an unread result.
`default_nettype none

module identity_number_check_digit_validator (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] ch,
	input  wire logic       last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            id_valid
);

	logic           valid_s1;
	logic [7:0]     ch_s1;
	logic           last_s1;
	logic           valid_s2;
	idv_pkg::snap_t snap_s2;
	idv_pkg::snap_t snap_next;
	logic           out_valid_q;
	logic           id_valid_q;

	logic           ready_o;
	logic           ready_s2;
	logic           adv_s1;
	logic           adv_s2;
	logic [3:0]     wrem;
	logic [3:0]     srem;
	logic           chk_ok;
	logic           verdict;

	// Stage handshakes
	assign ready_o  = !out_valid_q || out_ready;
	assign ready_s2 = !valid_s2 || ready_o;
	assign in_ready = !valid_s1 || ready_s2;
	assign adv_s1   = valid_s1 && ready_s2;
	assign adv_s2   = valid_s2 && ready_o;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	// Accumulator
	idv_acc u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ch_s1   (ch_s1),
		.last_s1 (last_s1),
		.upd     (adv_s1),
		.snap    (snap_next)
	);

	// Snapshot register: only final characters go on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= adv_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			snap_s2 <= snap_next;
		end
	end

	// Check digits; a negative weighted sum passes only on a zero remainder
	assign wrem    = idv_pkg::mod10(snap_s2.wsum_mag);
	assign srem    = idv_pkg::mod10({2'b00, snap_s2.sum10});
	assign chk_ok  = snap_s2.wsum_neg ? ((wrem == 4'd0) && (snap_s2.tenth == 4'd0))
	                                  : (wrem == snap_s2.tenth);
	assign verdict = snap_s2.base_ok && chk_ok && (srem == snap_s2.fin);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_o) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			id_valid_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign id_valid  = id_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/idv_chk.sv =====
// ----------------------------------------------------------------------------
// idv_chk: port-level checks for the identity number validator
// Watches the top-level ports and flags flow-control slips.
// ----------------------------------------------------------------------------
`default_nettype none

module idv_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [7:0] ch,
	input wire logic       last,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       id_valid
);

	// A waiting input transaction keeps its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |=> (in_valid && $stable(ch) && $stable(last)))
		else $error("input changed while stalled");

	// A stalled result transaction holds its verdict
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(id_valid)))
		else $error("result changed while stalled");

	// With the result register empty the pipeline has room for a character
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// No result straight out of reset
	a_no_result_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

endmodule

bind identity_number_check_digit_validator idv_chk u_idv_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.ch        (ch),
	.last      (last),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.id_valid  (id_valid)
);

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: identity number check-digit validator
// Streams identity-number strings into the block one character per
// transaction. The verdicts that come back are compared against a local
// predictor of the check rules. The run starts with a short directed table,
// then moves to random strings: mostly well-formed numbers with random
// content, plus corrupted, wrong-length and noisy strings. Idle bursts and
// stalls are applied on both sides.
// ----------------------------------------------------------------------------

module testbench;

	localparam int RANDOM_ITEMS = 1100;
	localparam int TOTAL_ITEMS  = 1500;
	localparam int HOLD_CYCLES  = 60;
	localparam int HOLD_ITEMS   = 40;
	localparam int DRAIN_CYCLES = 10;
	localparam int STALL_LIMIT  = 2000;

	// Where the expected verdict of a string comes from
	typedef enum logic [1:0] {
		VERDICT_MODEL,
		VERDICT_ZERO,
		VERDICT_ONE
	} verdict_src_t;

	typedef struct packed {
		logic [7:0]   chr;
		logic         eos;
		verdict_src_t src;
	} stim_row_t;

	// Directed strings: a valid number, the same number one digit too long,
	// and single-character strings at both ends of the byte range
	localparam stim_row_t DIRECTED [25] = '{
		'{"1", 1'b0, VERDICT_MODEL}, '{"0", 1'b0, VERDICT_MODEL},
		'{"0", 1'b0, VERDICT_MODEL}, '{"0", 1'b0, VERDICT_MODEL},
		'{"0", 1'b0, VERDICT_MODEL}, '{"0", 1'b0, VERDICT_MODEL},
		'{"0", 1'b0, VERDICT_MODEL}, '{"0", 1'b0, VERDICT_MODEL},
		'{"1", 1'b0, VERDICT_MODEL}, '{"4", 1'b0, VERDICT_MODEL},
		'{"6", 1'b1, VERDICT_MODEL},
		'{"1", 1'b0, VERDICT_ZERO}, '{"0", 1'b0, VERDICT_ZERO},
		'{"0", 1'b0, VERDICT_ZERO}, '{"0", 1'b0, VERDICT_ZERO},
		'{"0", 1'b0, VERDICT_ZERO}, '{"0", 1'b0, VERDICT_ZERO},
		'{"0", 1'b0, VERDICT_ZERO}, '{"0", 1'b0, VERDICT_ZERO},
		'{"1", 1'b0, VERDICT_ZERO}, '{"4", 1'b0, VERDICT_ZERO},
		'{"6", 1'b0, VERDICT_ZERO}, '{"0", 1'b1, VERDICT_ZERO},
		'{8'h00, 1'b1, VERDICT_ZERO},
		'{8'hFF, 1'b1, VERDICT_ZERO}
	};

	logic         clk = 1'b0;
	logic         arst_n;
	logic         in_valid;
	logic         in_ready;
	logic [7:0]   ch;
	logic         last;
	logic         out_valid;
	logic         out_ready;
	logic         id_valid;
	verdict_src_t row_src;

	// Predictor state, cleared after every verdict
	logic [3:0] pr_count;
	logic       pr_non_digit;
	logic       pr_lead_zero;
	logic [5:0] pr_sum_a;     // digits at positions 0,2,4,6,8
	logic [5:0] pr_sum_b;     // digits at positions 1,3,5,7
	logic [6:0] pr_sum10;
	logic [3:0] pr_tenth;

	logic       verdict_q [$];
	logic [7:0] str_buf [$];
	int         err_count = 0;
	int         items_sent = 0;
	int         idle_cycles = 0;
	bit         tx_idle_on = 1'b0;
	bit         quiet = 1'b0;
	bit         hold_req = 1'b0;

	identity_number_check_digit_validator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ch        (ch),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.id_valid  (id_valid)
	);

	always #5 clk = ~clk;

	// Predictor: one accepted character, verdict on the final one
	task automatic id_check_step(input logic [7:0] c, input logic fin_char,
			output logic fired, output logic verdict);
		logic [3:0] pos;
		logic       is_dig;
		logic [3:0] d;
		logic [3:0] check_digit;
		int         wsum;
		int         rem;
		pos         = pr_count;
		is_dig      = (c >= idv_pkg::CHAR_ZERO) && (c <= idv_pkg::CHAR_NINE);
		d           = is_dig ? 4'(c - idv_pkg::CHAR_ZERO) : 4'd0;
		check_digit = 4'd0;
		fired       = fin_char;
		verdict     = 1'b0;
		if (!is_dig)
			pr_non_digit = 1'b1;
		if (pos == 4'd0 && c == idv_pkg::CHAR_ZERO)
			pr_lead_zero = 1'b1;
		if (is_dig && pos < idv_pkg::FINAL_POS) begin
			pr_sum10 = pr_sum10 + 7'(d);
			if (pos < idv_pkg::CHK_POS) begin
				if (!pos[0])
					pr_sum_a = pr_sum_a + 6'(d);
				else
					pr_sum_b = pr_sum_b + 6'(d);
			end else begin
				pr_tenth = d;
			end
		end
		if (pos == idv_pkg::FINAL_POS)
			check_digit = d;
		if (pr_count < idv_pkg::CNT_SAT)
			pr_count = pr_count + 4'd1;
		if (fin_char) begin
			// truncating remainder: a negative weighted sum gives a negative or zero rem
			wsum    = 7 * int'(pr_sum_a) - int'(pr_sum_b);
			rem     = wsum % 10;
			verdict = (pr_count == idv_pkg::ID_LEN) && !pr_non_digit && !pr_lead_zero
				&& (rem == int'(pr_tenth))
				&& (int'(pr_sum10) % 10 == int'(check_digit));
			pr_count     = 4'd0;
			pr_non_digit = 1'b0;
			pr_lead_zero = 1'b0;
			pr_sum_a     = 6'd0;
			pr_sum_b     = 6'd0;
			pr_sum10     = 7'd0;
			pr_tenth     = 4'd0;
		end
	endtask

	// Monitor: predict on accepted input, compare on accepted output
	always @(posedge clk) begin : monitor
		logic fired;
		logic verdict;
		logic expected;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				id_check_step(ch, last, fired, verdict);
				if (fired) begin
					case (row_src)
						VERDICT_ZERO: verdict_q.push_back(1'b0);
						VERDICT_ONE:  verdict_q.push_back(1'b1);
						default:      verdict_q.push_back(verdict);
					endcase
				end
			end
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					$error("id_valid: no verdict expected, actual %0b", id_valid);
					err_count++;
				end else begin
					expected = verdict_q.pop_front();
					if (id_valid !== expected) begin
						$error("id_valid mismatch: expected %0b, actual %0b",
							expected, id_valid);
						err_count++;
					end
				end
			end
		end
	end

	// Watchdog on cycles without any accepted transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: random stall bursts, calm stretches, one long hold
	initial begin : receiver
		int stall_left;
		int calm_left;
		stall_left = 0;
		calm_left  = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!quiet && calm_left == 0 && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 3);
				calm_left  = ($urandom_range(0, 2) == 0) ? $urandom_range(10, 40) : 0;
			end else begin
				out_ready <= 1'b1;
				if (calm_left > 0)
					calm_left--;
			end
		end
	end

	// Offer one transaction and wait for it to be accepted
	task automatic send_item(input logic [7:0] c, input logic fin_char,
			input verdict_src_t src);
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		ch       <= c;
		last     <= fin_char;
		row_src  <= src;
		do @(posedge clk); while (in_ready !== 1'b1);
		items_sent++;
	endtask

	task automatic send_string();
		tx_idle_on = !quiet && ($urandom_range(0, 3) != 0);
		foreach (str_buf[i])
			send_item(str_buf[i], i == str_buf.size() - 1, VERDICT_MODEL);
	endtask

	// Stop offering and wait until every verdict is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (verdict_q.size() == 0);
	endtask

	// Well-formed number with check digits computed where possible
	task automatic build_checked_id(input int a_lo, input int a_hi,
			input int b_lo, input int b_hi);
		int dig [11];
		int sum_a;
		int sum_b;
		int rem;
		sum_a = 0;
		sum_b = 0;
		for (int i = 0; i < 9; i++) begin
			if (i % 2 == 0) begin
				dig[i] = $urandom_range(a_hi, a_lo);
				if (i == 0 && dig[i] == 0)
					dig[i] = 1;
				sum_a += dig[i];
			end else begin
				dig[i] = $urandom_range(b_hi, b_lo);
				sum_b += dig[i];
			end
		end
		rem    = (7 * sum_a - sum_b) % 10;
		dig[9] = (rem >= 0) ? rem : $urandom_range(0, 9);
		dig[10] = (sum_a + sum_b + dig[9]) % 10;
		str_buf.delete();
		for (int i = 0; i < 11; i++)
			str_buf.push_back(idv_pkg::CHAR_ZERO + 8'(dig[i]));
	endtask

	task automatic build_random_string();
		int kind;
		int len;
		kind = $urandom_range(0, 99);
		str_buf.delete();
		if (kind < 50) begin
			build_checked_id(0, 9, 0, 9);
		end else if (kind < 65) begin
			// one digit replaced, the leading one included
			build_checked_id(0, 9, 0, 9);
			str_buf[$urandom_range(0, 10)] = idv_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
		end else if (kind < 73) begin
			// small first group, large second: weighted sums that can go negative
			build_checked_id(0, 2, 6, 9);
		end else if (kind < 85) begin
			len = $urandom_range(1, 15);
			repeat (len) str_buf.push_back(idv_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
		end else begin
			len = ($urandom_range(0, 1) == 0) ? 11 : $urandom_range(1, 14);
			repeat (len) begin
				if ($urandom_range(0, 1) == 0)
					str_buf.push_back(8'($urandom_range(0, 255)));
				else
					str_buf.push_back(idv_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
			end
		end
	endtask

	// Main sequence
	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		ch        <= 8'h00;
		last      <= 1'b0;
		out_ready <= 1'b0;
		row_src   <= VERDICT_MODEL;
		pr_count     = 4'd0;
		pr_non_digit = 1'b0;
		pr_lead_zero = 1'b0;
		pr_sum_a     = 6'd0;
		pr_sum_b     = 6'd0;
		pr_sum10     = 7'd0;
		pr_tenth     = 4'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (DIRECTED[i])
			send_item(DIRECTED[i].chr, DIRECTED[i].eos, DIRECTED[i].src);

		// Random strings with idling on both sides
		while (items_sent < RANDOM_ITEMS) begin
			build_random_string();
			send_string();
		end
		drain();

		// Long receiver hold while single-character strings keep coming
		hold_req   = 1'b1;
		tx_idle_on = 1'b0;
		repeat (HOLD_ITEMS)
			send_item(8'($urandom_range(0, 255)), 1'b1, VERDICT_MODEL);
		drain();

		// Final stretch at full rate
		quiet = 1'b1;
		while (items_sent < TOTAL_ITEMS) begin
			build_random_string();
			send_string();
		end
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
